### rtl/mmct_pkg.sv
// ----------------------------------------------------------------------------
// mmct_pkg
// shared types, register indexes, reset values and result codes of the
// median/mad cfar trigger
// ----------------------------------------------------------------------------
package mmct_pkg;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int FLOOR_COUNT_DEF = 64;
  localparam int SCAN_COUNT_DEF  = 80;
  localparam int FLOOR_LAG_DEF   = 144;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_GAIN = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_GAIN      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RUN        = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_GAP   = 4'd3;

  localparam logic [7:0] THRESHOLD_GAIN_RST = 8'd12;
  localparam logic [7:0] HALF_GAIN_RST      = 8'd6;
  localparam logic [1:0] MIN_RUN_RST        = 2'd2;
  localparam logic [9:0] DEBOUNCE_GAP_RST   = 10'd80;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [1:0] CAUSE_OK       = 2'd0;
  localparam logic [1:0] CAUSE_LOW      = 2'd1;
  localparam logic [1:0] CAUSE_RUN      = 2'd2;
  localparam logic [1:0] CAUSE_DEBOUNCE = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [15:0] ns_sample;
    logic signed [15:0] ew_sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [7:0] threshold_gain;
    logic [7:0] half_gain;
    logic [1:0] min_run;
    logic [9:0] debounce_gap;
  } cfg_t;

  typedef struct packed {
    logic        detected;
    logic [1:0]  reject_cause;
    logic [9:0]  trigger_index;
    logic [31:0] peak_energy;
    logic [31:0] noise_floor;
    logic [31:0] noise_spread;
  } result_t;

endpackage

### rtl/mmct_queue.sv
// ----------------------------------------------------------------------------
// mmct_queue
// short item queue between the accepting front and the processing engine
// ----------------------------------------------------------------------------
module mmct_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmct_pkg::item_t din,
  output logic           q_full,
  output mmct_pkg::head_t head,
  input  logic           take
);

  localparam int QD = mmct_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  mmct_pkg::item_t slots [QD];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_take;

  assign q_full     = (count == CW'(QD));
  assign do_push    = push && !q_full;
  assign do_take    = take && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_take);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

### rtl/mmct_engine.sv
// ----------------------------------------------------------------------------
// mmct_engine
// energy ring, radix median selection, peak scan, run and debounce checks
// ----------------------------------------------------------------------------
module mmct_engine #(
  parameter int RING_DEPTH  = mmct_pkg::RING_DEPTH_DEF,
  parameter int FLOOR_COUNT = mmct_pkg::FLOOR_COUNT_DEF,
  parameter int SCAN_COUNT  = mmct_pkg::SCAN_COUNT_DEF,
  parameter int FLOOR_LAG   = mmct_pkg::FLOOR_LAG_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  mmct_pkg::head_t  head,
  output logic             take,
  input  mmct_pkg::cfg_t   cfg,
  output logic             clearing,
  output mmct_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_pop
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(FLOOR_COUNT + 1);
  localparam int MAXN = (FLOOR_COUNT > SCAN_COUNT) ? FLOOR_COUNT : SCAN_COUNT;
  localparam int IW   = $clog2(MAXN + 1);
  localparam logic [AW-1:0] RMAX     = AW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] LAST_RST = AW'((RING_DEPTH - (1000 % RING_DEPTH)) % RING_DEPTH);
  localparam logic [AW-1:0] LAG_OFS  = AW'(FLOOR_LAG % RING_DEPTH);
  localparam logic [CW-1:0] MED_K    = CW'(FLOOR_COUNT / 2);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MED   = 4'd2;
  localparam logic [3:0] S_LVL   = 4'd3;
  localparam logic [3:0] S_LVL2  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_RUN   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == RMAX) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    return (a == '0) ? RMAX : a - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = (a >= b) ? ({1'b0, a} - {1'b0, b})
                 : ({1'b0, a} + (AW+1)'(RING_DEPTH) - {1'b0, b});
    return s[AW-1:0];
  endfunction

  logic [31:0] ring [RING_DEPTH];

  logic [3:0]    state;
  logic [AW-1:0] clr;
  logic [AW-1:0] wp;
  logic [AW-1:0] last;
  logic [AW-1:0] fb;
  logic          sq_vld;
  logic [31:0]   ns2;
  logic [31:0]   ew2;
  logic [AW-1:0] ra;
  logic [IW-1:0] iss;
  logic          rvld;
  logic          rlast;
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic          med_sel;
  logic [31:0]   bsel;
  logic [31:0]   hi_mask;
  logic [31:0]   prefix;
  logic [CW-1:0] kk;
  logic [CW-1:0] cnt;
  logic [31:0]   floor_q;
  logic [31:0]   spread_q;
  logic [39:0]   thr_prod;
  logic [39:0]   run_prod;
  logic [40:0]   thr;
  logic [40:0]   run_lvl;
  logic [31:0]   peak;
  logic [AW-1:0] trig;
  logic          found;
  logic [1:0]    run_cnt;
  logic [1:0]    cause;

  logic signed [31:0] nsx;
  logic signed [31:0] ewx;
  logic          take_push;
  logic          take_eval;
  logic          rd_en;
  logic          rd_last;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [31:0]   val;
  logic          hit;
  logic [CW-1:0] cnt_sum;
  logic          go_low;
  logic [31:0]   pfx_fin;
  logic          run_hit;
  logic [1:0]    run_sum;
  logic [AW-1:0] delta;

  assign clearing  = (state == S_CLEAR);
  assign nsx       = 32'(head.item.ns_sample);
  assign ewx       = 32'(head.item.ew_sample);
  assign take_push = (state == S_IDLE) && head.valid && (head.item.action == mmct_pkg::ACT_PUSH);
  assign take_eval = (state == S_IDLE) && head.valid && (head.item.action == mmct_pkg::ACT_EVAL)
                     && !sq_vld;
  assign take      = take_push || take_eval;

  assign mem_we = clearing || sq_vld;
  assign mem_wa = clearing ? clr : wp;
  assign mem_wd = clearing ? '0 : ns2 + ew2;

  always_comb begin
    rd_en   = 1'b0;
    rd_last = 1'b0;
    case (state)
      S_MED: begin
        rd_en   = (iss < IW'(FLOOR_COUNT));
        rd_last = (iss == IW'(FLOOR_COUNT - 1));
      end
      S_SCAN: begin
        rd_en   = (iss < IW'(SCAN_COUNT));
        rd_last = (iss == IW'(SCAN_COUNT - 1));
      end
      S_RUN: begin
        rd_en   = (iss < IW'(3));
        rd_last = (iss == IW'(2));
      end
      default: begin
        rd_en   = 1'b0;
        rd_last = 1'b0;
      end
    endcase
  end

  // one radix digit of the median per pass over the floor window
  assign val     = !med_sel ? rdata : ((rdata >= floor_q) ? rdata - floor_q : floor_q - rdata);
  assign hit     = (((val ^ prefix) & hi_mask) == '0) && ((val & bsel) == '0);
  assign cnt_sum = cnt + CW'(hit);
  assign go_low  = (kk < cnt_sum);
  assign pfx_fin = go_low ? prefix : (prefix | bsel);

  assign run_hit = ({9'd0, rdata} > run_lvl);
  assign run_sum = run_cnt + 2'(run_hit);
  assign delta   = ring_sub(trig, last);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata <= ring[ra];
    end
    raddr <= ra;
    ns2   <= $unsigned(nsx * nsx);
    ew2   <= $unsigned(ewx * ewx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      wp        <= '0;
      last      <= LAST_RST;
      sq_vld    <= 1'b0;
      rvld      <= 1'b0;
      rlast     <= 1'b0;
      iss       <= '0;
      floor_q   <= 32'd1;
      spread_q  <= 32'd1;
      res_valid <= 1'b0;
    end else begin
      sq_vld <= take_push;
      rvld   <= rd_en;
      rlast  <= rd_en && rd_last;
      if (sq_vld) begin
        wp <= ring_inc(wp);
      end
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      if (rd_en) begin
        iss <= iss + 1'b1;
        ra  <= (state == S_SCAN) ? ring_dec(ra) : ring_inc(ra);
      end
      unique case (state)
        S_CLEAR: begin
          clr <= ring_inc(clr);
          if (clr == RMAX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take_eval) begin
            fb      <= ring_sub(wp, LAG_OFS);
            ra      <= ring_sub(wp, LAG_OFS);
            iss     <= '0;
            med_sel <= 1'b0;
            bsel    <= 32'h8000_0000;
            hi_mask <= '0;
            prefix  <= '0;
            kk      <= MED_K;
            cnt     <= '0;
            state   <= S_MED;
          end
        end
        S_MED: begin
          if (rvld) begin
            if (rlast) begin
              cnt <= '0;
              iss <= '0;
              ra  <= fb;
              if (bsel[0]) begin
                bsel    <= 32'h8000_0000;
                hi_mask <= '0;
                prefix  <= '0;
                kk      <= MED_K;
                if (!med_sel) begin
                  floor_q <= pfx_fin;
                  med_sel <= 1'b1;
                end else begin
                  spread_q <= pfx_fin;
                  state    <= S_LVL;
                end
              end else begin
                prefix  <= pfx_fin;
                kk      <= go_low ? kk : kk - cnt_sum;
                hi_mask <= hi_mask | bsel;
                bsel    <= bsel >> 1;
              end
            end else begin
              cnt <= cnt_sum;
            end
          end
        end
        S_LVL: begin
          thr_prod <= 40'(spread_q) * 40'(cfg.threshold_gain);
          run_prod <= 40'(spread_q) * 40'(cfg.half_gain);
          state    <= S_LVL2;
        end
        S_LVL2: begin
          thr     <= {9'd0, floor_q} + {1'b0, thr_prod};
          run_lvl <= {9'd0, floor_q} + {1'b0, run_prod};
          iss     <= '0;
          ra      <= ring_dec(wp);
          peak    <= '0;
          trig    <= '0;
          found   <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (rvld) begin
            if (rdata > peak) begin
              peak  <= rdata;
              trig  <= raddr;
              found <= 1'b1;
            end
            if (rlast) begin
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (!found || ({9'd0, peak} < thr)) begin
            cause <= mmct_pkg::CAUSE_LOW;
            state <= S_DONE;
          end else begin
            iss     <= '0;
            ra      <= ring_dec(trig);
            run_cnt <= '0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          if (rvld) begin
            run_cnt <= run_sum;
            if (rlast) begin
              state <= S_DONE;
              if (run_sum < cfg.min_run) begin
                cause <= mmct_pkg::CAUSE_RUN;
              end else if ((32'(delta) < 32'(cfg.debounce_gap)) && (delta != '0)) begin
                cause <= mmct_pkg::CAUSE_DEBOUNCE;
              end else begin
                cause <= mmct_pkg::CAUSE_OK;
                last  <= trig;
              end
            end
          end
        end
        S_DONE: begin
          if (!res_valid || res_pop) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!res_valid || res_pop)) begin
      res.detected      <= (cause == mmct_pkg::CAUSE_OK);
      res.reject_cause  <= cause;
      res.trigger_index <= 10'(trig);
      res.peak_energy   <= peak;
      res.noise_floor   <= floor_q;
      res.noise_spread  <= spread_q;
    end
  end

endmodule

### rtl/median_mad_cfar_trigger_top.sv
// ----------------------------------------------------------------------------
// median_mad_cfar_trigger_top
// cfar trigger on loop sample energy with median floor and mad spread
// ----------------------------------------------------------------------------
// push items: one per cycle while engine idle; queue, square register, then ring
// evaluate: 64 radix passes over the FLOOR_COUNT floor window (32 per median,
//   floor then spread, one ring read a cycle), scan, run check; one at a time
// result goes to the output register when the engine finishes and it is free
// reset: synchronous; full stays high while the ring is cleared
// ----------------------------------------------------------------------------
module median_mad_cfar_trigger_top #(
  parameter int RING_DEPTH  = mmct_pkg::RING_DEPTH_DEF,
  parameter int FLOOR_COUNT = mmct_pkg::FLOOR_COUNT_DEF,
  parameter int SCAN_COUNT  = mmct_pkg::SCAN_COUNT_DEF,
  parameter int FLOOR_LAG   = mmct_pkg::FLOOR_LAG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item input, queue style
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic signed [15:0] ns_sample,
  input  logic signed [15:0] ew_sample,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic        detected,
  output logic [1:0]  reject_cause,
  output logic [9:0]  trigger_index,
  output logic [31:0] peak_energy,
  output logic [31:0] noise_floor,
  output logic [31:0] noise_spread,
  // configuration writes
  input  logic        cfg_we,
  input  logic [mmct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mmct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mmct_pkg::cfg_t    cfg;
  mmct_pkg::item_t   din;
  mmct_pkg::head_t   head;
  mmct_pkg::result_t res;
  logic q_full;
  logic take;
  logic clearing;
  logic res_valid;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_gain <= mmct_pkg::THRESHOLD_GAIN_RST;
      cfg.half_gain      <= mmct_pkg::HALF_GAIN_RST;
      cfg.min_run        <= mmct_pkg::MIN_RUN_RST;
      cfg.debounce_gap   <= mmct_pkg::DEBOUNCE_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmct_pkg::REG_THRESHOLD_GAIN: cfg.threshold_gain <= cfg_data[7:0];
        mmct_pkg::REG_HALF_GAIN:      cfg.half_gain      <= cfg_data[7:0];
        mmct_pkg::REG_MIN_RUN:        cfg.min_run        <= cfg_data[1:0];
        mmct_pkg::REG_DEBOUNCE_GAP:   cfg.debounce_gap   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign din.action    = action;
  assign din.ns_sample = ns_sample;
  assign din.ew_sample = ew_sample;

  // no item gets in while the ring clear sweep runs
  assign full = q_full || clearing;

  // front: accepts items into a short queue
  mmct_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push && !clearing),
    .din    (din),
    .q_full (q_full),
    .head   (head),
    .take   (take)
  );

  // back: ring, medians, scan and decision
  mmct_engine #(
    .RING_DEPTH  (RING_DEPTH),
    .FLOOR_COUNT (FLOOR_COUNT),
    .SCAN_COUNT  (SCAN_COUNT),
    .FLOOR_LAG   (FLOOR_LAG)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .take      (take),
    .cfg       (cfg),
    .clearing  (clearing),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  // result register drives the output side
  assign empty         = !res_valid;
  assign detected      = res.detected;
  assign reject_cause  = res.reject_cause;
  assign trigger_index = res.trigger_index;
  assign peak_energy   = res.peak_energy;
  assign noise_floor   = res.noise_floor;
  assign noise_spread  = res.noise_spread;

endmodule

### rtl/mmct_checker.sv
// ----------------------------------------------------------------------------
// mmct_checker
// port level checks of the trigger, bound to the top level
// ----------------------------------------------------------------------------
module mmct_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        detected,
  input logic [1:0]  reject_cause,
  input logic [31:0] peak_energy,
  input logic [31:0] noise_floor
);

  // ring clear sweep blocks input right after reset
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("input open during ring clear");

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // an accepted trigger lies at or above the floor
  a_det_above_floor: assert property (@(posedge clk) disable iff (rst)
    (!empty && detected) |->
      (peak_energy >= noise_floor && reject_cause == mmct_pkg::CAUSE_OK))
    else $error("trigger below floor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(peak_energy) && $stable(reject_cause)))
    else $error("waiting result changed");

endmodule

bind median_mad_cfar_trigger_top mmct_checker u_mmct_checker (.*);
